// File: hw/rtl/lvrt_pkg.sv
// ----------------------------------------------------------------------------
// lvrt_pkg: shared types and constants
// Mode codes, controller command struct and fixed-point constants.
// ----------------------------------------------------------------------------
package lvrt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Q2.14 fixed point
  localparam int FRACTION_BITS = 14;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_RECOVERY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CFG_FAULT_LVL   = 3'd0,
    CFG_RECOV_LVL   = 3'd1,
    CFG_DROP_LVL    = 3'd2,
    CFG_GAIN        = 3'd3,
    CFG_CEILING     = 3'd4,
    CFG_SHARE       = 3'd5,
    CFG_DEBOUNCE    = 3'd6,
    CFG_RELEASE_DLY = 3'd7
  } cfg_idx_t;

  // commands from controller to datapath
  typedef struct packed {
    logic eval;       // idle/active/recovery decision on the latched sample
    logic mult_start; // start the split/cap computation
    logic sqrt_step;  // one root step; the first one loads the root operand
    logic finish;     // write back results
  } lvrt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_issue; // a current issue is needed
    logic sqrt_done;
  } lvrt_sts_t;

  function automatic logic [31:0] step_time(input logic [2:0] k);
    case (k)
      3'd0:    step_time = 32'd50;
      3'd1:    step_time = 32'd150;
      3'd2:    step_time = 32'd500;
      default: step_time = 32'd1000;
    endcase
  endfunction

endpackage

// File: hw/rtl/lvrt_if.sv
// ----------------------------------------------------------------------------
// lvrt_in_if / lvrt_out_if: sample and result channels
// Valid/ready channels carrying the sample and the result payloads.
// ----------------------------------------------------------------------------
interface lvrt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;
  logic [15:0] grid_voltage;
  modport source (output valid, time_ms, grid_voltage, input ready);
  modport sink (input valid, time_ms, grid_voltage, output ready);
endinterface

interface lvrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [14:0] compensator_current;
  logic [14:0] inverter_current;
  logic [14:0] active_power_cap;
  logic        compensator_current_mode;
  logic        compensator_in_ride;
  logic        inverter_in_ride;
  logic        tap_changer_locked;
  logic [5:0]  events;
  logic [2:0]  release_step;
  modport source (output valid, mode, compensator_current, inverter_current,
    active_power_cap, compensator_current_mode, compensator_in_ride,
    inverter_in_ride, tap_changer_locked, events, release_step, input ready);
  modport sink (input valid, mode, compensator_current, inverter_current,
    active_power_cap, compensator_current_mode, compensator_in_ride,
    inverter_in_ride, tap_changer_locked, events, release_step, output ready);
endinterface

// File: hw/rtl/lvrt_ctrl.sv
// ----------------------------------------------------------------------------
// lvrt_ctrl: sequencing state machine
// Accepts a sample; eval, then multiply and root only when issuing, finish.
// ----------------------------------------------------------------------------
module lvrt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output lvrt_pkg::lvrt_cmd_t cmd,
  input  lvrt_pkg::lvrt_sts_t sts
);
  import lvrt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_MUL  = 6'b000100,
    S_SQRT = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);
  assign take     = in_valid && in_ready;
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EVAL;
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        if (sts.need_issue) begin
          cmd.mult_start = 1'b1;
          state_next = S_SQRT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end
endmodule

// File: hw/rtl/lvrt_dp.sv
// ----------------------------------------------------------------------------
// lvrt_dp: controller datapath
// Mode state, demand multiply, split multiplies and a bit-serial square root.
// ----------------------------------------------------------------------------
module lvrt_dp #(
  parameter int RELEASE_STEPS = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [31:0]         time_ms,
  input  logic [15:0]         grid_voltage,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_data,
  input  lvrt_pkg::lvrt_cmd_t cmd,
  output lvrt_pkg::lvrt_sts_t sts,
  output logic [1:0]          mode,
  output logic [14:0]         compensator_current,
  output logic [14:0]         inverter_current,
  output logic [14:0]         active_power_cap,
  output logic                compensator_current_mode,
  output logic                compensator_in_ride,
  output logic                inverter_in_ride,
  output logic                tap_changer_locked,
  output logic [5:0]          events,
  output logic [2:0]          release_step
);
  import lvrt_pkg::*;

  localparam int ONE_W = FRACTION_BITS + 1;
  localparam logic [ONE_W-1:0] ONE_PU = ONE_W'(1) << FRACTION_BITS;
  localparam int SW = (RELEASE_STEPS > 4) ? 4 : 3;  // room for the count itself

  // configuration registers
  logic [15:0] fault_lvl, recov_lvl, drop_lvl, gain, release_dly;
  logic [14:0] ceiling, share;
  logic [7:0]  debounce_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_lvl <= 16'd14746; recov_lvl <= 16'd14746; drop_lvl <= 16'd1638;
      gain <= 16'd8192; ceiling <= 15'd18022; share <= 15'd8192;
      debounce_n <= 8'd4; release_dly <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FAULT_LVL:   fault_lvl <= cfg_data;
        CFG_RECOV_LVL:   recov_lvl <= cfg_data;
        CFG_DROP_LVL:    drop_lvl <= cfg_data;
        CFG_GAIN:        gain <= cfg_data;
        CFG_CEILING:     ceiling <= cfg_data[14:0];
        CFG_SHARE:       share <= cfg_data[14:0];
        CFG_DEBOUNCE:    debounce_n <= cfg_data[7:0];
        CFG_RELEASE_DLY: release_dly <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample latch, demand product taken with the sample
  logic [31:0] now;
  logic [15:0] v;
  logic [15:0] in_deficit;
  logic [31:0] dprod;
  assign in_deficit = (grid_voltage < fault_lvl) ? fault_lvl - grid_voltage : 16'd0;
  always_ff @(posedge clk) if (take) begin
    now <= time_ms;
    v <= grid_voltage;
    dprod <= gain * in_deficit;
  end

  // state
  mode_t       mode_reg;
  logic [7:0]  deb;
  logic [15:0] prev_v;
  logic [31:0] fault_start, recov_start;
  logic [SW-1:0] step_idx;
  logic [17:0] demand;
  logic [14:0] comp_cmd, inv_cmd, cap_cmd;
  logic        f_cmode, f_cride, f_iride, f_tap;
  logic [5:0]  ev;
  logic        issue;

  // demand = round(gain*deficit/4096), saturated
  logic [20:0] dshift;
  logic [17:0] nd_raw, nd_clamp, diff;
  logic [24:0] diff100;
  assign dshift  = 21'((33'(dprod) + 33'd2048) >> 12);
  assign nd_raw  = (dshift > 21'd262143) ? 18'h3FFFF : dshift[17:0];
  assign nd_clamp = (nd_raw > 18'(ceiling)) ? 18'(ceiling) : nd_raw;
  assign diff = (nd_clamp > demand) ? nd_clamp - demand : demand - nd_clamp;
  assign diff100 = 25'(diff) * 25'd100;

  logic low, drop;
  logic [7:0] deb_n;
  assign low = v < fault_lvl;
  assign drop = ($signed({2'b0, prev_v}) - $signed({2'b0, v})) > $signed({2'b0, drop_lvl});
  assign deb_n = (low && drop) ? ((deb == 8'hFF) ? deb : deb + 8'd1) : 8'd0;

  // recovery step chain: at most RELEASE_STEPS narrow dependent steps
  logic [31:0] relapsed;
  logic [SW-1:0] st_n;
  logic [3:0] rel_fl;
  logic rel_idle;
  logic [5:0] rel_ev;
  assign relapsed = now - recov_start;
  always_comb begin
    st_n = step_idx;
    rel_fl = '0; rel_idle = 1'b0; rel_ev = '0;
    for (int i = 0; i < RELEASE_STEPS; i++) begin
      if (int'(st_n) == i && relapsed >= step_time(3'(i))) begin
        if (i == 0 || i == RELEASE_STEPS - 1) rel_fl[2] = 1'b1;
        if (i == 1 || i == RELEASE_STEPS - 1) begin rel_fl[1] = 1'b1; rel_fl[0] = 1'b1; end
        if (i == 2 || i == RELEASE_STEPS - 1) rel_fl[3] = 1'b1;
        if (i == RELEASE_STEPS - 1) rel_idle = 1'b1;
        if (i < 4) rel_ev = rel_ev | 6'(4 << i);
        st_n = SW'(i + 1);
      end
    end
  end

  // evaluation of the latched sample
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg <= MODE_IDLE; deb <= '0; prev_v <= 16'd16384;
      fault_start <= '0; recov_start <= '0; step_idx <= '0; demand <= '0;
      f_cmode <= 1'b0; f_cride <= 1'b0; f_iride <= 1'b0; f_tap <= 1'b0;
      ev <= '0; issue <= 1'b0;
    end else if (cmd.eval) begin
      ev <= '0; issue <= 1'b0;
      prev_v <= v;
      unique case (mode_reg)
        MODE_IDLE: begin
          deb <= deb_n;
          if (deb_n >= debounce_n) begin
            mode_reg <= MODE_ACTIVE; fault_start <= now; demand <= nd_raw;
            {f_cmode, f_cride, f_iride, f_tap} <= 4'hF;
            ev <= 6'd1; issue <= 1'b1;
          end
        end
        MODE_ACTIVE: begin
          if (v >= recov_lvl && (now - fault_start) > 32'(release_dly)) begin
            mode_reg <= MODE_RECOVERY; recov_start <= now; step_idx <= '0;
          end else if (low && 26'(diff100) > 26'(ONE_PU)) begin
            demand <= nd_clamp; ev <= 6'd2; issue <= 1'b1;
          end
        end
        default: begin
          step_idx <= st_n;
          if (rel_fl[0]) f_cmode <= 1'b0;
          if (rel_fl[1]) f_cride <= 1'b0;
          if (rel_fl[2]) f_iride <= 1'b0;
          if (rel_fl[3]) f_tap <= 1'b0;
          if (rel_idle) mode_reg <= MODE_IDLE;
          ev <= rel_ev;
        end
      endcase
    end
  end
  assign sts.need_issue = issue;

  // split multiplies and root operand, one multiply per register
  logic [14:0] iq, shr;
  logic [29:0] sq_iq, sq_ceil;
  logic [14:0] comp_n, inv_n;
  assign iq  = (demand > 18'(ceiling)) ? ceiling : demand[14:0];
  assign shr = (share > 15'(ONE_PU)) ? 15'(ONE_PU) : share;

  logic [1:0] mstage;
  logic [4:0] sq_cnt;
  logic [29:0] sq_x;
  logic [31:0] sq_r;
  logic [31:0] sq_bit;
  logic [35:0] pc, pi;
  always_ff @(posedge clk) begin
    if (rst) begin
      mstage <= '0; sq_cnt <= '0;
    end else if (cmd.mult_start) begin
      pc <= 36'(iq) * 36'(shr) + 36'(ONE_PU >> 1);
      pi <= 36'(iq) * 36'(ONE_PU - ONE_W'(shr)) + 36'(ONE_PU >> 1);
      sq_iq <= iq * iq;
      sq_ceil <= ceiling * ceiling;
      mstage <= 2'd1;
      sq_cnt <= '0;
    end else if (cmd.sqrt_step) begin
      if (mstage == 2'd1) begin
        sq_x <= sq_ceil - sq_iq;
        sq_r <= '0;
        sq_bit <= 32'h4000_0000;
        mstage <= 2'd2;
      end else begin
        if ({2'b0, sq_x} >= sq_r + sq_bit) begin
          sq_x <= 30'({2'b0, sq_x} - (sq_r + sq_bit));
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        sq_cnt <= sq_cnt + 5'd1;
      end
    end
  end
  assign sts.sqrt_done = (mstage == 2'd2) && (sq_cnt == 5'd15);
  assign comp_n = 15'(pc >> FRACTION_BITS);
  assign inv_n  = 15'(pi >> FRACTION_BITS);

  // result write back
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_cmd <= '0; inv_cmd <= '0; cap_cmd <= 15'd16384;
    end else if (cmd.finish) begin
      if (issue) begin
        comp_cmd <= comp_n; inv_cmd <= inv_n;
        cap_cmd <= sq_r[14:0];
      end else if (ev[5:2] != 4'd0 && !f_iride && mode_reg != MODE_ACTIVE) begin
        cap_cmd <= 15'd16384;
      end
    end
  end

  assign mode = mode_reg;
  assign compensator_current = comp_cmd;
  assign inverter_current = inv_cmd;
  assign active_power_cap = cap_cmd;
  assign compensator_current_mode = f_cmode;
  assign compensator_in_ride = f_cride;
  assign inverter_in_ride = f_iride;
  assign tap_changer_locked = f_tap;
  assign events = ev;
  assign release_step = 3'(step_idx);
endmodule

// File: hw/rtl/low_voltage_ride_through_controller.sv
// ----------------------------------------------------------------------------
// low_voltage_ride_through_controller: LVRT top level
//
//   channel   dir   payload
//   smp       in    time_ms, grid_voltage
//   res       out   mode, currents, cap, flags, events, release_step
//   cfg       in    cfg_we, cfg_idx, cfg_data
//
// a sample that issues a current also runs the 16-iteration bit-serial
// square root; one that issues none skips the multiply and root
// one sample in flight at a time; the result holds until transferred
// rst is synchronous and restores control, config and result reset values
// ----------------------------------------------------------------------------
module low_voltage_ride_through_controller #(
  parameter int RELEASE_STEPS = 4
) (
  input logic clk,
  input logic rst,
  lvrt_in_if.sink    smp,
  lvrt_out_if.source res,
  input logic        cfg_we,
  input logic [lvrt_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input logic [lvrt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lvrt_pkg::*;

  lvrt_cmd_t cmd;
  lvrt_sts_t sts;
  logic take;

  lvrt_ctrl u_ctrl (
    .clk, .rst, .in_valid(smp.valid), .in_ready(smp.ready), .take,
    .out_valid(res.valid), .out_ready(res.ready), .cmd, .sts
  );

  lvrt_dp #(.RELEASE_STEPS(RELEASE_STEPS)) u_dp (
    .clk, .rst, .take, .time_ms(smp.time_ms), .grid_voltage(smp.grid_voltage),
    .cfg_we, .cfg_idx, .cfg_data, .cmd, .sts,
    .mode(res.mode), .compensator_current(res.compensator_current),
    .inverter_current(res.inverter_current), .active_power_cap(res.active_power_cap),
    .compensator_current_mode(res.compensator_current_mode),
    .compensator_in_ride(res.compensator_in_ride),
    .inverter_in_ride(res.inverter_in_ride),
    .tap_changer_locked(res.tap_changer_locked),
    .events(res.events), .release_step(res.release_step)
  );
endmodule

// File: hw/rtl/lvrt_checker.sv
// ----------------------------------------------------------------------------
// lvrt_checker: port-level checks
// Watches the top level's channels and flags illegal result patterns.
// ----------------------------------------------------------------------------
module lvrt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] mode,
  input logic       iride,
  input logic [5:0] events
);
  import lvrt_pkg::*;

  // no new sample while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("sample taken with result pending");
  // result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(events))
    else $error("result dropped");
  // fault entry reports active mode
  a_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && events[0] |-> mode == MODE_ACTIVE) else $error("entry without active");
  // in active the inverters ride through
  a_ride: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_ACTIVE |-> iride) else $error("active without ride");
endmodule

bind low_voltage_ride_through_controller lvrt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(smp.valid), .in_ready(smp.ready),
  .out_valid(res.valid), .out_ready(res.ready), .mode(res.mode),
  .iride(res.inverter_in_ride), .events(res.events)
);
